@@ sv/finite_difference_bvp_solver_top_defines.svh @@
// ----------------------------------------------------------------------------
// finite_difference_bvp_solver_top_defines
// Assertion macros for the finite-difference BVP solver.
// ----------------------------------------------------------------------------
`ifndef FINITE_DIFFERENCE_BVP_SOLVER_TOP_DEFINES_SVH
`define FINITE_DIFFERENCE_BVP_SOLVER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define FDB_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define FDB_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define FDB_ASSERT(label, clk, rst_n, prop, msg)
`define FDB_ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

@@ sv/fdb_pkg.sv @@
// ----------------------------------------------------------------------------
// fdb_pkg
// Shared constants, types and fixed-point helpers of the BVP solver.
// ----------------------------------------------------------------------------
package fdb_pkg;
  localparam int MaxIntervals = 63;
  localparam int FracBits     = 24;
  localparam int IdxW         = 6;
  localparam int DataW        = 32;

  localparam logic [0:0] CfgIdxGrid = 1'b0;
  localparam logic [0:0] CfgIdxOffd = 1'b1;

  // Channel payloads
  typedef struct packed {
    logic [0:0]       idx;
    logic [DataW-1:0] val;
  } cfg_item_t;

  typedef struct packed {
    logic signed [DataW-1:0] left_boundary;
    logic signed [DataW-1:0] right_boundary;
  } bvp_item_t;

  typedef struct packed {
    logic [IdxW-1:0]         point_index;
    logic signed [DataW-1:0] grid_position;
    logic signed [DataW-1:0] solution_value;
    logic                    last_point;
  } grid_point_t;

  typedef struct packed {
    logic                    start;
    logic signed [DataW-1:0] num;
    logic signed [DataW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                    done;
    logic signed [DataW-1:0] quo;
  } div_rsp_t;

  function automatic logic signed [31:0] sat64(input logic signed [65:0] v);
    if (v > 66'sd2147483647) return 32'sh7fffffff;
    if (v < -66'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] fx_add(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
    return sat64(66'(a) + 66'(b));
  endfunction

  function automatic logic signed [31:0] fx_sub(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
    return sat64(66'(a) - 66'(b));
  endfunction

  // Rounds to nearest, ties toward +inf: floor((p + half) / 2^F).
  function automatic logic signed [31:0] fx_round(input logic signed [63:0] p,
                                                  input int unsigned f);
    logic signed [65:0] r;
    r = (66'(p) + (66'sd1 <<< (f - 1))) >>> f;
    return sat64(r);
  endfunction
endpackage

@@ sv/fdb_if.sv @@
// ----------------------------------------------------------------------------
// fdb_if
// Valid/ready channel carrying one payload item.
// ----------------------------------------------------------------------------
interface fdb_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ sv/fdb_ram.sv @@
// ----------------------------------------------------------------------------
// fdb_ram
// Single-port-write, single-read synchronous RAM, registered read.
// ----------------------------------------------------------------------------
module fdb_ram #(
  parameter int Width = 32,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

@@ sv/fdb_div.sv @@
// ----------------------------------------------------------------------------
// fdb_div
// Restoring fixed-point divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`include "finite_difference_bvp_solver_top_defines.svh"
module fdb_div #(
  parameter int FracBits = fdb_pkg::FracBits
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  fdb_pkg::div_req_t req_i,
  output fdb_pkg::div_rsp_t rsp_o
);
  import fdb_pkg::*;
  localparam int NumW = DataW + FracBits + 1;
  localparam int CntW = $clog2(NumW + 1);

  logic            busy_q, busy_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [NumW-1:0] num_q, num_d;
  logic [DataW:0]  den_q, den_d;
  logic [DataW+1:0] rem_q, rem_d;
  logic            neg_q, neg_d;
  logic            done_q, done_d;
  logic signed [DataW-1:0] quo_q, quo_d;
  logic [DataW:0]  un, ud;
  logic [DataW+1:0] trial;
  logic [NumW:0]   qf;

  always_comb begin
    busy_d = busy_q; cnt_d = cnt_q; num_d = num_q; den_d = den_q;
    rem_d = rem_q; neg_d = neg_q; done_d = 1'b0; quo_d = quo_q;
    un = req_i.num[DataW-1] ? (DataW+1)'(-33'(req_i.num)) : (DataW+1)'(req_i.num);
    ud = req_i.den[DataW-1] ? (DataW+1)'(-33'(req_i.den)) : (DataW+1)'(req_i.den);
    trial = {rem_q[DataW:0], num_q[NumW-1]} - {1'b0, den_q};
    qf = '0;
    if (req_i.start) begin
      if (req_i.den == '0) begin
        done_d = 1'b1;
        quo_d  = req_i.num[DataW-1] ? 32'sh80000000 : 32'sh7fffffff;
      end else begin
        busy_d = 1'b1; cnt_d = CntW'(NumW);
        // numerator scaled by 2^F, plus half the divisor folded in as
        // doubled numerator: compute q2 = floor(2n*2^F/d), q=(q2+1)>>1
        num_d = NumW'({un, FracBits'(0)}) << 1;
        den_d = ud; rem_d = '0;
        neg_d = req_i.num[DataW-1] ^ req_i.den[DataW-1];
        quo_d = '0;
      end
    end else if (busy_q) begin
      if (!trial[DataW+1]) rem_d = trial;
      else rem_d = {rem_q[DataW:0], num_q[NumW-1]};
      num_d = {num_q[NumW-2:0], ~trial[DataW+1]};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0; done_d = 1'b1;
        qf = ((NumW+1)'(num_d) + 1'b1) >> 1;
        if (neg_q) begin
          if (qf > (NumW+1)'(64'h80000000)) quo_d = 32'sh80000000;
          else quo_d = DataW'(-qf);
        end else begin
          if (qf > (NumW+1)'(64'h7fffffff)) quo_d = 32'sh7fffffff;
          else quo_d = DataW'(qf);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; cnt_q <= '0; done_q <= 1'b0;
    end else begin
      busy_q <= busy_d; cnt_q <= cnt_d; done_q <= done_d;
    end
  end
  always_ff @(posedge clk_i) begin
    num_q <= num_d; den_q <= den_d; rem_q <= rem_d; neg_q <= neg_d; quo_q <= quo_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;

  `FDB_ASSERT(a_div_no_restart, clk_i, rst_ni, busy_q |-> !req_i.start, "divider restarted while busy")
  `FDB_ASSERT_NEVER(a_div_done_busy, clk_i, rst_ni, done_q && busy_q, "done while busy")
  `FDB_ASSERT(a_div_cnt, clk_i, rst_ni, busy_q |-> cnt_q != '0, "busy with zero count")
endmodule

@@ sv/finite_difference_bvp_solver_top.sv @@
// ----------------------------------------------------------------------------
// finite_difference_bvp_solver_top
// Finite-difference BVP solver on [-1,1] by tridiagonal (Thomas) elimination.
// ----------------------------------------------------------------------------
// Usage:
//  - cfg channel: index 0 writes grid_intervals N, index 1 writes off_diagonal
//    b. Write only while the block is idle.
//  - in channel: one item holds left and right boundary values (Q8.24).
//  - out channel: N+1 items (point_index, grid_position, solution_value,
//    last_point), in order of i, last_point high on i = N.
//  - Work: h = 2/N takes one division. Each of the N-1 forward rows does a
//    grid division, five multiply steps and two solver divisions (one on
//    the last row) in the shared one-bit-per-cycle divider. Back
//    substitution needs no division. Each output point needs its own
//    grid division and waits out any receiver stall. The divider dominates.
//  - One item is processed at a time; in.ready is high only when idle.
//  - Reset returns N=8, b=-1.0, and the sequencer to idle; the stores are
//    not cleared (every entry is written before it is read).
//  - A stalled receiver holds the output item; the sequencer waits.
// ----------------------------------------------------------------------------
`include "finite_difference_bvp_solver_top_defines.svh"
module finite_difference_bvp_solver_top #(
  parameter int MaxIntervals = fdb_pkg::MaxIntervals,
  parameter int FracBits     = fdb_pkg::FracBits
) (
  input  logic clk_i,
  input  logic rst_ni,
  fdb_if.sink   cfg,
  fdb_if.sink   in_ch,
  fdb_if.source out_ch
);
  import fdb_pkg::*;
  localparam int AW    = $clog2(MaxIntervals + 1);
  localparam int RamAW = $clog2(MaxIntervals - 1);
  localparam logic signed [31:0] One = 32'sd1 <<< FracBits;

  localparam logic [3:0] S_IDLE = 4'd0, S_H = 4'd1, S_HW = 4'd2, S_X = 4'd3,
    S_XW = 4'd4, S_ROW = 4'd5, S_ZD = 4'd6, S_ZW = 4'd7, S_UD = 4'd8,
    S_UW = 4'd9, S_BS = 4'd10, S_BSR = 4'd11, S_OX = 4'd12, S_OXW = 4'd13,
    S_OUT = 4'd14, S_OR = 4'd15;

  // cfg payload: {index, data}
  logic [IdxW-1:0]  grid_q;
  logic signed [31:0] b_q;
  logic [3:0] st_q, st_d;
  logic [AW-1:0] n_q, k_q, k_d;
  logic signed [31:0] left_q, right_q, h_q, h2_q, x_q, t_q, prev_u_q, prev_z_q;
  logic signed [31:0] l_q, ox_q, sol_q;
  logic signed [31:0] hd, h2d, xd, td;
  div_req_t dreq;
  div_rsp_t drsp;

  // stores
  logic we_l, we_u, we_z, we_w;
  logic [AW-1:0] a_u, a_z, a_w, ra_u, ra_z, ra_w;
  logic signed [31:0] wd_u, wd_z, wd_w, wd_l, rd_l, rd_u, rd_z, rd_w;
  logic [AW-1:0] nn;

  always_comb begin
    nn = (grid_q < 6'd2) ? AW'(2) :
         (32'(grid_q) > MaxIntervals) ? AW'(MaxIntervals) : AW'(grid_q);
  end

  assign cfg.ready = (st_q == S_IDLE);
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_q <= 6'd8; b_q <= -One;
    end else if (cfg.valid && cfg.ready) begin
      if (cfg.data.idx == CfgIdxGrid) grid_q <= cfg.data.val[IdxW-1:0];
      else b_q <= cfg.data.val;
    end
  end

  fdb_div #(.FracBits(FracBits)) u_div (.clk_i, .rst_ni, .req_i(dreq), .rsp_o(drsp));

  fdb_ram #(.Width(32), .Depth(MaxIntervals - 1)) u_pivot (.clk_i, .we_i(we_l),
    .waddr_i(RamAW'(k_q)), .wdata_i(wd_l),
    .raddr_i(RamAW'(k_q)), .rdata_o(rd_l));
  fdb_ram #(.Width(32), .Depth(MaxIntervals - 1)) u_upper (.clk_i, .we_i(we_u),
    .waddr_i(RamAW'(a_u)), .wdata_i(wd_u),
    .raddr_i(RamAW'(ra_u)), .rdata_o(rd_u));
  fdb_ram #(.Width(32), .Depth(MaxIntervals - 1)) u_fwd (.clk_i, .we_i(we_z),
    .waddr_i(RamAW'(a_z)), .wdata_i(wd_z),
    .raddr_i(RamAW'(ra_z)), .rdata_o(rd_z));
  fdb_ram #(.Width(32), .Depth(MaxIntervals + 1)) u_sol (.clk_i, .we_i(we_w),
    .waddr_i(a_w), .wdata_i(wd_w), .raddr_i(ra_w), .rdata_o(rd_w));

  // combinational helpers (one multiply per register stage is kept by
  // computing in dedicated states)
  logic signed [31:0] mul_a, mul_b, mul_r;
  assign mul_r = fx_round(64'(mul_a) * 64'(mul_b), FracBits);

  assign in_ch.ready = (st_q == S_IDLE);
  assign out_ch.valid = (st_q == S_OUT);
  assign out_ch.data.point_index    = IdxW'(k_q);
  assign out_ch.data.grid_position  = ox_q;
  assign out_ch.data.solution_value = sol_q;
  assign out_ch.data.last_point     = (k_q == n_q);

  // row step registers
  logic [2:0] ph_q, ph_d;

  always_comb begin
    st_d = st_q; k_d = k_q; ph_d = ph_q;
    dreq = '0; mul_a = '0; mul_b = '0;
    we_l = 1'b0; we_u = 1'b0; we_z = 1'b0; we_w = 1'b0;
    wd_l = '0; wd_u = drsp.quo; wd_z = drsp.quo; wd_w = '0;
    a_u = k_q; a_z = k_q; a_w = k_q;
    ra_u = k_q - 1'b1; ra_z = k_q - 1'b1; ra_w = k_q;
    hd = h_q; h2d = h2_q; xd = x_q; td = t_q;
    case (st_q)
      S_IDLE: if (in_ch.valid) st_d = S_H;
      S_H: begin
        dreq.start = 1'b1; dreq.num = 32'sd2; dreq.den = 32'(n_q);
        st_d = S_HW;
      end
      S_HW: if (drsp.done) begin
        // quo = round(2*2^F/n) since num=2 scaled by 2^F
        hd = drsp.quo; st_d = S_X; k_d = '0; ph_d = '0;
      end
      S_X: begin
        // x_(k+1) = round(2(k+1)2^F/n) - 1
        if (ph_q == 3'd0) begin
          mul_a = h_q; mul_b = h_q; h2d = mul_r; ph_d = 3'd1;
        end else begin
          dreq.start = 1'b1; dreq.num = 32'(2 * (32'(k_q) + 1)); dreq.den = 32'(n_q);
          st_d = S_XW;
        end
      end
      S_XW: if (drsp.done) begin
        xd = fx_sub(drsp.quo, One); st_d = S_ROW; ph_d = '0;
      end
      S_ROW: begin
        case (ph_q)
          3'd0: begin mul_a = x_q; mul_b = x_q; td = fx_add(One, mul_r); ph_d = 3'd1; end
          3'd1: begin mul_a = h2_q; mul_b = t_q; td = fx_add(2 * One, mul_r); ph_d = 3'd2; end
          3'd2: begin
            // t = a; l = a - b*u(k-1)
            mul_a = b_q; mul_b = prev_u_q;
            td = (k_q == '0) ? t_q : fx_sub(t_q, mul_r); ph_d = 3'd3;
          end
          3'd3: begin
            mul_a = b_q; mul_b = prev_z_q; xd = h2_q;
            if (k_q == '0) xd = fx_add(xd, left_q);
            if (k_q == n_q - 2) xd = fx_add(xd, right_q);
            if (k_q != '0) xd = fx_sub(xd, mul_r);
            we_l = 1'b1; wd_l = t_q; ph_d = 3'd4;
          end
          default: begin
            dreq.start = 1'b1; dreq.num = x_q; dreq.den = t_q; st_d = S_ZD;
          end
        endcase
      end
      S_ZD: if (drsp.done) begin
        // upper factor only while a later row follows
        we_z = 1'b1; ph_d = '0;
        if (k_q + 2 < n_q) st_d = S_UD; else st_d = S_BS;
      end
      S_UD: begin
        dreq.start = 1'b1; dreq.num = b_q; dreq.den = rd_l; st_d = S_UW;
      end
      S_UW: if (drsp.done) begin
        we_u = 1'b1; k_d = k_q + 1'b1; ph_d = '0; st_d = S_X;
      end
      S_BS: begin
        // write w0, wn, w(n-1); then i from n-2 down to 1
        case (ph_q)
          3'd0: begin we_w = 1'b1; a_w = '0; wd_w = left_q; ph_d = 3'd1; end
          3'd1: begin we_w = 1'b1; a_w = n_q; wd_w = right_q; ph_d = 3'd2; end
          default: begin
            we_w = 1'b1; a_w = n_q - 1'b1; wd_w = prev_z_q;
            k_d = n_q - 2'd2; ph_d = '0;
            st_d = (n_q == AW'(2)) ? S_OX : S_BSR;
            if (n_q == AW'(2)) k_d = '0;
          end
        endcase
      end
      S_BSR: begin
        // read u(i-1), z(i-1), w(i+1); addresses held until the compute phase
        ra_u = k_q - 1'b1; ra_z = k_q - 1'b1; ra_w = k_q + 1'b1;
        if (ph_q == 3'd0) begin
          ph_d = 3'd1;
        end else if (ph_q == 3'd1) begin
          ph_d = 3'd2;
        end else begin
          mul_a = rd_u; mul_b = rd_w;
          we_w = 1'b1; a_w = k_q; wd_w = fx_sub(rd_z, mul_r);
          ph_d = '0;
          if (k_q == AW'(1)) begin k_d = '0; st_d = S_OX; end
          else k_d = k_q - 1'b1;
        end
      end
      S_OX: begin
        dreq.start = 1'b1; dreq.num = 32'(2 * 32'(k_q)); dreq.den = 32'(n_q);
        ra_w = k_q; st_d = S_OXW;
      end
      S_OXW: begin
        ra_w = k_q;
        if (drsp.done) st_d = S_OUT;
      end
      S_OUT: if (out_ch.ready) begin
        if (k_q == n_q) st_d = S_IDLE;
        else begin k_d = k_q + 1'b1; st_d = S_OX; end
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE; k_q <= '0; ph_q <= '0;
    end else begin
      st_q <= st_d; k_q <= k_d; ph_q <= ph_d;
    end
  end

  always_ff @(posedge clk_i) begin
    h_q <= hd; h2_q <= h2d; x_q <= xd; t_q <= td;
    if (st_q == S_IDLE && in_ch.valid) begin
      left_q <= in_ch.data.left_boundary; right_q <= in_ch.data.right_boundary;
      n_q <= nn; prev_u_q <= '0; prev_z_q <= '0;
    end
    if (st_q == S_ZD && drsp.done) prev_z_q <= drsp.quo;
    if (st_q == S_UW && drsp.done) prev_u_q <= drsp.quo;
    if (st_q == S_OXW && drsp.done) begin
      ox_q <= fx_sub(drsp.quo, One); sol_q <= rd_w;
    end
  end

  `FDB_ASSERT(a_out_hold, clk_i, rst_ni, (out_ch.valid && !out_ch.ready) |=> out_ch.valid, "out lost")
  `FDB_ASSERT_NEVER(a_busy_in, clk_i, rst_ni, in_ch.ready && st_q != S_IDLE, "input while busy")
  `FDB_ASSERT(a_last, clk_i, rst_ni, (out_ch.valid && out_ch.ready && out_ch.data.last_point) |=> st_q == S_IDLE, "no end")
endmodule
